/* rtl/core/dnsenc_pkg.sv */
// ----------------------------------------------------------------------------
// dnsenc_pkg
// shared types, constants and helpers of the dns name wire encoder
// ----------------------------------------------------------------------------
package dnsenc_pkg;

  localparam int unsigned NameLimitDef  = 253;
  localparam int unsigned LabelLimitDef = 63;

  localparam logic [7:0] DotChar = 8'd46;
  localparam logic [7:0] EndChar = 8'd0;

  localparam int unsigned BufSizeW = 16;
  localparam int unsigned TdataW   = 32;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NAME_LONG  = 2'd1,
    ST_NO_SPACE   = 2'd2,
    ST_LABEL_LONG = 2'd3
  } status_e;

  typedef struct packed {
    logic       is_write;
    logic [7:0] write_address;
    logic [7:0] write_data;
    status_e    status;
    logic [7:0] encoded_length;
    logic       last;
  } result_t;

  // up to three results pushed per input byte, packed from slot 0 up
  typedef struct packed {
    logic [1:0]        cnt;
    result_t [2:0]     res;
  } push_t;

  function automatic result_t mk_write(logic [7:0] addr, logic [7:0] data);
    result_t r;
    r.is_write       = 1'b1;
    r.write_address  = addr;
    r.write_data     = data;
    r.status         = ST_OK;
    r.encoded_length = 8'd0;
    r.last           = 1'b0;
    return r;
  endfunction

  function automatic result_t mk_status(status_e st, logic [7:0] len);
    result_t r;
    r.is_write       = 1'b0;
    r.write_address  = 8'd0;
    r.write_data     = 8'd0;
    r.status         = st;
    r.encoded_length = len;
    r.last           = 1'b1;
    return r;
  endfunction

endpackage

/* rtl/core/dnsenc_core.sv */
// ----------------------------------------------------------------------------
// dnsenc_core
// input register, label / name state and per-byte result generation
// ----------------------------------------------------------------------------
module dnsenc_core #(
  parameter int unsigned NAME_LIMIT  = dnsenc_pkg::NameLimitDef,
  parameter int unsigned LABEL_LIMIT = dnsenc_pkg::LabelLimitDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dnsenc_pkg::BufSizeW-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          in_byte_i,
  input  logic                                room_i,
  output dnsenc_pkg::push_t                   push_o
);

  localparam logic [8:0] NameLim  = 9'(NAME_LIMIT);
  localparam logic [6:0] LabelLim = 7'(LABEL_LIMIT);

  logic [dnsenc_pkg::BufSizeW-1:0] bsize_q;
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic [7:0] ls_q, ls_d;
  logic [6:0] lc_q, lc_d;
  logic [8:0] nc_q, nc_d;
  logic       ltl_q, ltl_d;

  logic       consume, is_end, is_dot;
  logic [8:0] nc_inc;
  logic [6:0] lc_inc;
  logic       ltl_chr, err_dot, err_chr;
  logic [8:0] addr_chr;
  logic [7:0] ls_close, ls_end;
  logic       nc_over_buf;
  logic       va, vb, vc;
  dnsenc_pkg::result_t ra, rb, rc;

  assign consume    = in_vld_q & room_i;
  assign in_ready_o = ~in_vld_q | room_i;
  assign in_vld_d   = in_ready_o ? in_valid_i : in_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsize_q  <= '0;
      in_vld_q <= 1'b0;
      ls_q     <= '0;
      lc_q     <= '0;
      nc_q     <= '0;
      ltl_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bsize_q <= cfg_wdata_i;
      end
      in_vld_q <= in_vld_d;
      ls_q     <= ls_d;
      lc_q     <= lc_d;
      nc_q     <= nc_d;
      ltl_q    <= ltl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
  end

  always_comb begin
    is_end   = (in_byte_q == dnsenc_pkg::EndChar);
    is_dot   = (in_byte_q == dnsenc_pkg::DotChar);
    nc_inc   = (nc_q <= NameLim) ? nc_q + 9'd1 : nc_q;
    lc_inc   = (lc_q <= LabelLim) ? lc_q + 7'd1 : lc_q;
    ltl_chr  = ltl_q | (lc_inc > LabelLim);
    err_dot  = (nc_inc > NameLim) | (({7'd0, nc_inc} + 16'd1) > bsize_q) | ltl_q;
    err_chr  = (nc_inc > NameLim) | (({7'd0, nc_inc} + 16'd1) > bsize_q) | ltl_chr;
    addr_chr = {1'b0, ls_q} + {2'd0, lc_inc};
    ls_close = ls_q + {1'b0, lc_q} + 8'd1;
    ls_end   = (lc_q != 7'd0) ? ls_close : ls_q;
    nc_over_buf = (({7'd0, nc_q} + 16'd1) > bsize_q);

    va = 1'b0;
    vb = 1'b0;
    vc = 1'b0;
    ra = dnsenc_pkg::mk_write(ls_q, {1'b0, lc_q});
    rb = dnsenc_pkg::mk_write(ls_end, 8'd0);
    rc = dnsenc_pkg::mk_status(dnsenc_pkg::ST_OK, 8'd0);

    ls_d  = ls_q;
    lc_d  = lc_q;
    nc_d  = nc_q;
    ltl_d = ltl_q;

    if (consume) begin
      if (is_end) begin
        vc    = 1'b1;
        ls_d  = '0;
        lc_d  = '0;
        nc_d  = '0;
        ltl_d = 1'b0;
        if (nc_q > NameLim) begin
          rc = dnsenc_pkg::mk_status(dnsenc_pkg::ST_NAME_LONG, 8'd0);
        end else if (bsize_q == '0 && nc_q == 9'd0) begin
          rc = dnsenc_pkg::mk_status(dnsenc_pkg::ST_OK, 8'd0);
        end else if (nc_over_buf) begin
          rc = dnsenc_pkg::mk_status(dnsenc_pkg::ST_NO_SPACE, 8'd0);
        end else if (ltl_q) begin
          rc = dnsenc_pkg::mk_status(dnsenc_pkg::ST_LABEL_LONG, 8'd0);
        end else begin
          // close the open label, then the terminating zero
          va = (lc_q != 7'd0) && ({8'd0, ls_q} < bsize_q);
          vb = ({8'd0, ls_end} < bsize_q);
          rc = dnsenc_pkg::mk_status(dnsenc_pkg::ST_OK, ls_end);
        end
      end else if (is_dot) begin
        nc_d = nc_inc;
        lc_d = '0;
        va   = ~err_dot && (lc_q != 7'd0) && ({8'd0, ls_q} < bsize_q);
        if (!err_dot) begin
          ls_d = ls_close;
        end
      end else begin
        nc_d  = nc_inc;
        lc_d  = lc_inc;
        ltl_d = ltl_chr;
        ra    = dnsenc_pkg::mk_write(addr_chr[7:0], in_byte_q);
        va    = ~err_chr && ({7'd0, addr_chr} < bsize_q);
      end
    end

    // pack valid candidates toward slot 0, status always last
    push_o.res[0] = va ? ra : (vb ? rb : rc);
    push_o.res[1] = va ? (vb ? rb : rc) : rc;
    push_o.res[2] = rc;
    push_o.cnt    = {1'b0, va} + {1'b0, vb} + {1'b0, vc};
  end

endmodule

/* rtl/core/dnsenc_resq.sv */
// ----------------------------------------------------------------------------
// dnsenc_resq
// four-entry result queue, up to three pushes and one pop per cycle
// ----------------------------------------------------------------------------
module dnsenc_resq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dnsenc_pkg::push_t    push_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dnsenc_pkg::result_t  out_res_o
);

  dnsenc_pkg::result_t mem_q [4];
  logic [1:0] head_q, head_d;
  logic [1:0] tail_q, tail_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_res_o   = mem_q[head_q];
  assign pop         = out_valid_o & out_ready_i;
  // a full push of three must always fit
  assign room_o      = (cnt_q <= 3'd1);

  always_comb begin
    head_d = head_q + {1'b0, pop};
    tail_d = tail_q + push_i.cnt;
    cnt_d  = cnt_q + {1'b0, push_i.cnt} - {2'd0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push_i.cnt) begin
        mem_q[tail_q + 2'(k)] <= push_i.res[k];
      end
    end
  end

endmodule

/* rtl/core/dns_name_wire_encoder_top.sv */
// ----------------------------------------------------------------------------
// dns_name_wire_encoder_top
// streaming dns name to wire-format label encoder
// ----------------------------------------------------------------------------
// A dotted hostname enters one byte per beat on the slave stream, closed by a
// zero byte. Each ordinary character gives one buffer-write beat at
// label_start+count+1, a dot gives the label length beat at label_start (none
// for an empty label), and the zero byte gives the pending label length, the
// terminating zero and a status beat (tlast high) carrying the final status
// and encoded length. Writes at or beyond buffer_size are dropped, and after
// an error is seen no more writes are issued for that name. Timing: one byte
// is taken every cycle while the result queue has room; a byte is held in
// the input register and then pushed into the result queue, whose beats
// leave one per cycle while m_axis_tready is high. The four-entry result
// queue must have room for three beats before a byte is processed, so the
// zero byte, which can make three beats, holds the input back while the
// queue drains, as does a stalled master stream. buffer_size is written
// through cfg_we_i; the user is bound to write it only while no name is in
// progress, and the block has no check for this.
// ----------------------------------------------------------------------------
module dns_name_wire_encoder_top #(
  parameter int unsigned NAME_LIMIT  = dnsenc_pkg::NameLimitDef,
  parameter int unsigned LABEL_LIMIT = dnsenc_pkg::LabelLimitDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration: buffer_size
  input  logic                              cfg_we_i,
  input  logic [dnsenc_pkg::BufSizeW-1:0]   cfg_wdata_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] name_byte
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] write_address, [15:8] write_data, [17:16] status,
  // [25:18] encoded_length, [31:26] zero
  output logic [dnsenc_pkg::TdataW-1:0]     m_axis_tdata,
  output logic                              m_axis_tuser,  // [0] is_write
  output logic                              m_axis_tlast   // last
);

  dnsenc_pkg::push_t   push;
  dnsenc_pkg::result_t out_res;
  logic                room;

  // state, input register and per-byte decision
  dnsenc_core #(
    .NAME_LIMIT  (NAME_LIMIT),
    .LABEL_LIMIT (LABEL_LIMIT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .room_i      (room),
    .push_o      (push)
  );

  // result queue, also the output register
  dnsenc_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  // pack beat fields, lowest field first
  assign m_axis_tdata = {6'd0, out_res.encoded_length, out_res.status,
                         out_res.write_data, out_res.write_address};
  assign m_axis_tuser = out_res.is_write;
  assign m_axis_tlast = out_res.last;

endmodule

/* rtl/core/dnsenc_checker.sv */
// ----------------------------------------------------------------------------
// dnsenc_checker
// port-level checks of the dns name wire encoder, bound to the top level
// ----------------------------------------------------------------------------
module dnsenc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [dnsenc_pkg::TdataW-1:0]     m_axis_tdata,
  input logic                              m_axis_tuser,
  input logic                              m_axis_tlast
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // status beat is never a write and closes the run
  a_status_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser)
    else $error("status beat flagged as write");

  // write beats carry no status, length or padding
  a_write_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[31:16] == 16'd0) && !m_axis_tlast)
    else $error("write beat carries status fields");

  // length only reported on a good status
  a_len_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && (m_axis_tdata[17:16] != dnsenc_pkg::ST_OK)
      |-> (m_axis_tdata[25:18] == 8'd0))
    else $error("length reported with error status");

endmodule

bind dns_name_wire_encoder_top dnsenc_checker u_dnsenc_checker (.*);
